// ===== hw/rtl/lwscd_pkg.sv =====
// Package for the sector cache directory: function codes, controller states,
// directory entry and result record types. No dependencies.
`default_nettype none

package lwscd_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned FTOT_W  = 7;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned FUNC_W  = 3;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_READ  = 3'd0,
    FUNC_WRITE = 3'd1,
    FUNC_MARK  = 3'd2,
    FUNC_SYNC  = 3'd3,
    FUNC_INVAL = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_FL_ISSUE,
    ST_FL_WAIT
  } state_e;

  // One directory entry as held in the tag/stamp memory.
  typedef struct packed {
    logic [ADDR_W-1:0]  tag;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // One result record.
  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic               wb;
    logic [ADDR_W-1:0]  wb_addr;
    logic               fill;
    logic [FTOT_W-1:0]  ftotal;
    logic [CNT_W-1:0]   hit_total;
    logic [CNT_W-1:0]   miss_total;
    logic               last;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lru_writeback_sector_cache_directory.sv =====
// Top level of the fully associative write-back sector cache directory with
// LRU replacement. Depends on lwscd_pkg, lwscd_mem and lwscd_outreg.
//
// Usage:
//   Request channel (in_valid_i / in_stall_o) moves a function code and a
//   sector address; a transfer happens when valid is high and stall is low.
//   Result channel (out_valid_o / out_stall_i) moves one result record per
//   transfer; last_o marks the final result of a request.
//   Read, write and mark dirty scan all ENTRIES directory slots through the
//   tag/stamp memory, one slot per cycle, then commit, one request at a
//   time. The scan goes over the single read port of the memory.
//   Sync and invalidate walk the slots in order; each dirty slot is read
//   from the memory, then its result is given. They give one result per
//   dirty slot and none when nothing is dirty. Unused codes give no result.
//   A result waits in an output register while out_stall_i is high; the
//   walk holds until that register frees, and the next request may be taken
//   while the last result still waits.
//   Reset empties the directory at once (valid and dirty flags are flops)
//   and clears the use clock and hit/miss totals; no clearing pass.
`default_nettype none

module lru_writeback_sector_cache_directory #(
  parameter int unsigned ENTRIES = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [2:0]  func_i,
  input  wire  [31:0] sector_addr_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic        hit_o,
  output logic [5:0]  slot_o,
  output logic        writeback_needed_o,
  output logic [31:0] writeback_addr_o,
  output logic        fill_needed_o,
  output logic [6:0]  flush_total_o,
  output logic [31:0] hit_total_o,
  output logic [31:0] miss_total_o,
  output logic        last_o
);
  import lwscd_pkg::*;

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  state_e state_q, state_d;

  // Directory flags, cleared at reset.
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [ENTRIES-1:0] dirty_q, dirty_d;

  logic [STAMP_W-1:0] use_clock_q, use_clock_d;
  logic [CNT_W-1:0]   hits_q, hits_d;
  logic [CNT_W-1:0]   misses_q, misses_d;

  // Request and walk bookkeeping.
  logic [FUNC_W-1:0]  func_q, func_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [FTOT_W-1:0]  ftot_q, ftot_d;
  logic               rd_vld_q, rd_vld_d;
  logic [IW-1:0]      rd_idx_q, rd_idx_d;

  // Scan results.
  logic               hit_fnd_q, hit_fnd_d;
  logic [IW-1:0]      hit_idx_q, hit_idx_d;
  logic               inv_fnd_q, inv_fnd_d;
  logic [IW-1:0]      inv_idx_q, inv_idx_d;
  logic [IW-1:0]      min_idx_q, min_idx_d;
  logic [STAMP_W-1:0] min_stamp_q, min_stamp_d;
  logic [ADDR_W-1:0]  min_tag_q, min_tag_d;

  // Memory ports.
  logic               mem_we, mem_re;
  logic [IW-1:0]      mem_waddr, mem_raddr;
  entry_t             mem_wdata, mem_rdata;

  // Output register.
  logic               out_load, out_free;
  res_t               res_d, res_o;

  logic [ENTRIES-1:0] above;
  logic               more_dirty;
  logic [IW-1:0]      cnt_idx;
  logic [IW-1:0]      vic_idx;
  logic               vic_wb;

  assign cnt_idx = cnt_q[IW-1:0];

  // Slots above the current walk position that still need a flush.
  always_comb begin
    for (int j = 0; j < ENTRIES; j++) begin
      above[j] = (CW'(j) > cnt_q);
    end
  end
  assign more_dirty = |(valid_q & dirty_q & above);

  // Victim: first free slot, else the oldest stamp.
  assign vic_idx = inv_fnd_q ? inv_idx_q : min_idx_q;
  assign vic_wb  = !inv_fnd_q && dirty_q[min_idx_q];

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    dirty_d     = dirty_q;
    use_clock_d = use_clock_q;
    hits_d      = hits_q;
    misses_d    = misses_q;
    func_d      = func_q;
    addr_d      = addr_q;
    cnt_d       = cnt_q;
    ftot_d      = ftot_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    hit_fnd_d   = hit_fnd_q;
    hit_idx_d   = hit_idx_q;
    inv_fnd_d   = inv_fnd_q;
    inv_idx_d   = inv_idx_q;
    min_idx_d   = min_idx_q;
    min_stamp_d = min_stamp_q;
    min_tag_d   = min_tag_q;
    mem_we      = 1'b0;
    mem_waddr   = vic_idx;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = cnt_idx;
    out_load    = 1'b0;
    res_d       = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          func_d    = func_i;
          addr_d    = sector_addr_i;
          cnt_d     = '0;
          ftot_d    = '0;
          hit_fnd_d = 1'b0;
          inv_fnd_d = 1'b0;
          case (func_i)
            FUNC_READ, FUNC_WRITE, FUNC_MARK: state_d = ST_SCAN;
            FUNC_SYNC, FUNC_INVAL:            state_d = ST_FL_ISSUE;
            default:                          state_d = ST_IDLE;
          endcase
        end
      end

      ST_SCAN: begin
        // Issue one read per cycle; check the slot read last cycle.
        if (cnt_q < CW'(ENTRIES)) begin
          mem_re   = 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = cnt_idx;
          cnt_d    = cnt_q + CW'(1);
        end else if (!rd_vld_q) begin
          state_d = ST_COMMIT;
        end
        if (rd_vld_q) begin
          if (valid_q[rd_idx_q] && mem_rdata.tag == addr_q && !hit_fnd_q) begin
            hit_fnd_d = 1'b1;
            hit_idx_d = rd_idx_q;
          end
          if (!valid_q[rd_idx_q] && !inv_fnd_q) begin
            inv_fnd_d = 1'b1;
            inv_idx_d = rd_idx_q;
          end
          if (rd_idx_q == '0 || mem_rdata.stamp < min_stamp_q) begin
            min_idx_d   = rd_idx_q;
            min_stamp_d = mem_rdata.stamp;
            min_tag_d   = mem_rdata.tag;
          end
        end
      end

      ST_COMMIT: begin
        if (out_free) begin
          out_load      = 1'b1;
          state_d       = ST_IDLE;
          res_d.last    = 1'b1;
          res_d.hit     = hit_fnd_q;
          case (func_q)
            FUNC_READ: begin
              use_clock_d = use_clock_q + STAMP_W'(1);
              mem_we      = 1'b1;
              mem_wdata   = '{tag: addr_q, stamp: use_clock_d};
              if (hit_fnd_q) begin
                hits_d     = hits_q + CNT_W'(1);
                mem_waddr  = hit_idx_q;
                res_d.slot = SLOT_W'(hit_idx_q);
              end else begin
                misses_d         = misses_q + CNT_W'(1);
                valid_d[vic_idx] = 1'b1;
                dirty_d[vic_idx] = 1'b0;
                res_d.slot       = SLOT_W'(vic_idx);
                res_d.wb         = vic_wb;
                res_d.wb_addr    = vic_wb ? min_tag_q : '0;
                res_d.fill       = 1'b1;
              end
            end
            FUNC_WRITE: begin
              mem_we    = 1'b1;
              if (hit_fnd_q) begin
                use_clock_d        = use_clock_q + STAMP_W'(1);
                dirty_d[hit_idx_q] = 1'b1;
                mem_waddr          = hit_idx_q;
                res_d.slot         = SLOT_W'(hit_idx_q);
              end else begin
                // A write miss advances the use clock by two before stamping its slot.
                use_clock_d      = use_clock_q + STAMP_W'(2);
                valid_d[vic_idx] = 1'b1;
                dirty_d[vic_idx] = 1'b1;
                res_d.slot       = SLOT_W'(vic_idx);
                res_d.wb         = vic_wb;
                res_d.wb_addr    = vic_wb ? min_tag_q : '0;
              end
              mem_wdata = '{tag: addr_q, stamp: use_clock_d};
            end
            FUNC_MARK: begin
              if (hit_fnd_q) begin
                dirty_d[hit_idx_q] = 1'b1;
                res_d.slot         = SLOT_W'(hit_idx_q);
              end
            end
            default: begin
              out_load = 1'b0;
            end
          endcase
          res_d.hit_total  = hits_d;
          res_d.miss_total = misses_d;
        end
      end

      ST_FL_ISSUE: begin
        if (cnt_q == CW'(ENTRIES)) begin
          state_d = ST_IDLE;
          if (func_q == FUNC_INVAL) begin
            valid_d = '0;
            dirty_d = '0;
          end
        end else if (valid_q[cnt_idx] && dirty_q[cnt_idx]) begin
          mem_re  = 1'b1;
          state_d = ST_FL_WAIT;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end

      ST_FL_WAIT: begin
        // Hold the read data until the output register takes the flush.
        if (out_free) begin
          out_load         = 1'b1;
          ftot_d           = ftot_q + FTOT_W'(1);
          dirty_d[cnt_idx] = 1'b0;
          cnt_d            = cnt_q + CW'(1);
          state_d          = ST_FL_ISSUE;
          res_d.slot       = SLOT_W'(cnt_idx);
          res_d.wb         = 1'b1;
          res_d.wb_addr    = mem_rdata.tag;
          res_d.ftotal     = ftot_d;
          res_d.hit_total  = hits_q;
          res_d.miss_total = misses_q;
          res_d.last       = !more_dirty;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      dirty_q     <= '0;
      use_clock_q <= '0;
      hits_q      <= '0;
      misses_q    <= '0;
      cnt_q       <= '0;
      ftot_q      <= '0;
      rd_vld_q    <= 1'b0;
      hit_fnd_q   <= 1'b0;
      inv_fnd_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      dirty_q     <= dirty_d;
      use_clock_q <= use_clock_d;
      hits_q      <= hits_d;
      misses_q    <= misses_d;
      cnt_q       <= cnt_d;
      ftot_q      <= ftot_d;
      rd_vld_q    <= rd_vld_d;
      hit_fnd_q   <= hit_fnd_d;
      inv_fnd_q   <= inv_fnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    addr_q      <= addr_d;
    rd_idx_q    <= rd_idx_d;
    hit_idx_q   <= hit_idx_d;
    inv_idx_q   <= inv_idx_d;
    min_idx_q   <= min_idx_d;
    min_stamp_q <= min_stamp_d;
    min_tag_q   <= min_tag_d;
  end

  lwscd_mem #(
    .ENTRIES (ENTRIES)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  lwscd_outreg u_outreg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (out_load),
    .data_i  (res_d),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (res_o)
  );

  assign hit_o              = res_o.hit;
  assign slot_o             = res_o.slot;
  assign writeback_needed_o = res_o.wb;
  assign writeback_addr_o   = res_o.wb_addr;
  assign fill_needed_o      = res_o.fill;
  assign flush_total_o      = res_o.ftotal;
  assign hit_total_o        = res_o.hit_total;
  assign miss_total_o       = res_o.miss_total;
  assign last_o             = res_o.last;

`ifndef ASSERT_OFF
  // A slot is never dirty without being valid.
  a_dirty_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dirty_q & ~valid_q) == '0)
    else $error("dirty flag set on an invalid slot");

  // The use clock advances by at most two per request.
  a_clock_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (use_clock_q - $past(use_clock_q)) <= STAMP_W'(2))
    else $error("use clock jumped");

  // A hit never asks for a fill.
  a_hit_no_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && fill_needed_o))
    else $error("hit result with fill request");

  // Flush results always carry a write-back and no hit.
  a_flush_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && flush_total_o != '0) |-> (writeback_needed_o && !hit_o))
    else $error("flush result without write-back");

  // A loaded result is only produced while a request is in flight.
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (state_q == ST_COMMIT || state_q == ST_FL_WAIT))
    else $error("result loaded outside commit or flush");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/lwscd_mem.sv =====
// Tag and use-stamp memory of the directory: one write port, one read port,
// registered read data. Depends on lwscd_pkg.
`default_nettype none

module lwscd_mem #(
  parameter int unsigned ENTRIES = 64
) (
  input  wire                          clk_i,
  input  wire                          we_i,
  input  wire [$clog2(ENTRIES)-1:0]    waddr_i,
  input  wire lwscd_pkg::entry_t       wdata_i,
  input  wire                          re_i,
  input  wire [$clog2(ENTRIES)-1:0]    raddr_i,
  output lwscd_pkg::entry_t            rdata_o
);
  import lwscd_pkg::*;

  entry_t mem [ENTRIES];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lwscd_outreg.sv =====
// Result holding register between the directory controller and the
// downstream receiver. Depends on lwscd_pkg.
`default_nettype none

module lwscd_outreg (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 load_i,
  input  wire lwscd_pkg::res_t data_i,
  output logic                free_o,
  output logic                valid_o,
  input  wire                 stall_i,
  output lwscd_pkg::res_t     data_o
);
  import lwscd_pkg::*;

  logic valid_q, valid_d;
  res_t data_q;

  // Free when empty or when the held result transfers this cycle.
  assign free_o = !valid_q || !stall_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking bench for the LRU write-back sector cache directory.
// Drives requests, mirrors the directory state and checks every result;
// depends on lwscd_pkg and the lru_writeback_sector_cache_directory RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lwscd_pkg::*;

  localparam int ENTRIES        = 64;
  localparam int POOL_SIZE      = 96;
  localparam int ITEMS_PER_PASS = 83;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 2 * ENTRIES + 20;
  localparam logic [2:0] FIRST_UNUSED_FUNC = 3'd5;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] addr;
  } sector_req_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic [2:0]  func_i         = '0;
  logic [31:0] sector_addr_i  = '0;
  logic        out_stall_i    = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        hit_o;
  logic [5:0]  slot_o;
  logic        writeback_needed_o;
  logic [31:0] writeback_addr_o;
  logic        fill_needed_o;
  logic [6:0]  flush_total_o;
  logic [31:0] hit_total_o;
  logic [31:0] miss_total_o;
  logic        last_o;

  lru_writeback_sector_cache_directory #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .func_i             (func_i),
    .sector_addr_i      (sector_addr_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .hit_o              (hit_o),
    .slot_o             (slot_o),
    .writeback_needed_o (writeback_needed_o),
    .writeback_addr_o   (writeback_addr_o),
    .fill_needed_o      (fill_needed_o),
    .flush_total_o      (flush_total_o),
    .hit_total_o        (hit_total_o),
    .miss_total_o       (miss_total_o),
    .last_o             (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mirror of the directory.
  logic        dir_valid [ENTRIES];
  logic        dir_dirty [ENTRIES];
  logic [31:0] dir_tag   [ENTRIES];
  logic [31:0] dir_stamp [ENTRIES];
  logic [31:0] use_clock   = '0;
  logic [31:0] read_hits   = '0;
  logic [31:0] read_misses = '0;

  sector_req_t pending_reqs[$];
  res_t        due_results[$];
  logic [31:0] addr_pool[POOL_SIZE];

  int  reqs_queued   = 0;
  int  reqs_taken    = 0;
  int  err_cnt       = 0;
  int  quiet_cycles  = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  logic req_fire     = 1'b0;
  res_t got_due;
  sector_req_t next_req;

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      dir_valid[i] = 1'b0;
      dir_dirty[i] = 1'b0;
      dir_tag[i]   = '0;
      dir_stamp[i] = '0;
    end
  end

  // Work out the results one request causes and advance the mirror.
  task automatic predict_directory(input logic [2:0] func, input logic [31:0] addr);
    int   s;
    int   n;
    res_t r;
    s = -1;
    n = 0;
    r = '0;
    if (func == FUNC_READ || func == FUNC_WRITE || func == FUNC_MARK) begin
      for (int i = ENTRIES - 1; i >= 0; i--)
        if (dir_valid[i] && dir_tag[i] == addr) s = i;
      r.last = 1'b1;
      if (s >= 0) begin
        r.hit = 1'b1;
        if (func == FUNC_READ) read_hits++;
        else dir_dirty[s] = 1'b1;
        // mark dirty leaves the stamp alone
        if (func != FUNC_MARK) begin
          use_clock++;
          dir_stamp[s] = use_clock;
        end
      end else if (func != FUNC_MARK) begin
        // take the lowest free slot, else evict the oldest stamp
        for (int i = ENTRIES - 1; i >= 0; i--)
          if (!dir_valid[i]) s = i;
        if (s < 0) begin
          s = 0;
          for (int i = 1; i < ENTRIES; i++)
            if (dir_stamp[i] < dir_stamp[s]) s = i;
          if (dir_dirty[s]) begin
            r.wb      = 1'b1;
            r.wb_addr = dir_tag[s];
          end
        end
        dir_tag[s]   = addr;
        dir_valid[s] = 1'b1;
        dir_dirty[s] = (func == FUNC_WRITE);
        // a write miss advances the use clock by two before stamping its entry
        use_clock    = use_clock + ((func == FUNC_WRITE) ? 32'd2 : 32'd1);
        dir_stamp[s] = use_clock;
        if (func == FUNC_READ) begin
          read_misses++;
          r.fill = 1'b1;
        end
      end
      if (s >= 0) r.slot = s[SLOT_W-1:0];
      r.hit_total  = read_hits;
      r.miss_total = read_misses;
      due_results.push_back(r);
    end else if (func == FUNC_SYNC || func == FUNC_INVAL) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (dir_valid[i] && dir_dirty[i]) begin
          dir_dirty[i] = 1'b0;
          n++;
          r            = '0;
          r.slot       = i[SLOT_W-1:0];
          r.wb         = 1'b1;
          r.wb_addr    = dir_tag[i];
          r.ftotal     = n[FTOT_W-1:0];
          r.hit_total  = read_hits;
          r.miss_total = read_misses;
          due_results.push_back(r);
        end
      end
      if (n > 0) begin
        r = due_results.pop_back();
        r.last = 1'b1;
        due_results.push_back(r);
      end
      if (func == FUNC_INVAL) begin
        for (int i = 0; i < ENTRIES; i++) begin
          dir_valid[i] = 1'b0;
          dir_dirty[i] = 1'b0;
          dir_tag[i]   = '0;
          dir_stamp[i] = '0;
        end
      end
    end
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endfunction

  task automatic queue_request(input logic [2:0] func, input logic [31:0] addr);
    pending_reqs.push_back('{func: func, addr: addr});
    reqs_queued++;
  endtask

  // Mostly reads and writes over a small address pool so hits, fills and
  // evictions all happen; flushes and unused codes now and then.
  task automatic queue_random_request();
    int          pick;
    logic [2:0]  func;
    logic [31:0] addr;
    pick = $urandom_range(99);
    if (pick < 42)      func = FUNC_READ;
    else if (pick < 72) func = FUNC_WRITE;
    else if (pick < 84) func = FUNC_MARK;
    else if (pick < 91) func = FUNC_SYNC;
    else if (pick < 92) func = FUNC_INVAL;
    else if (pick < 95) func = FIRST_UNUSED_FUNC + 3'($urandom_range(2));
    else                func = FUNC_READ;
    if ($urandom_range(99) < 25) addr = $urandom();
    else                         addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
    queue_request(func, addr);
  endtask

  // Hold off until every request is taken and every result has come back.
  task automatic drain();
    while (reqs_taken != reqs_queued || due_results.size() != 0) @(negedge clk_i);
  endtask

  // Driver: advance to the next request once the current one transfers.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || req_fire) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = pending_reqs.pop_front();
          in_valid_i    <= 1'b1;
          func_i        <= next_req.func;
          sector_addr_i <= next_req.addr;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: check each result transfer against the oldest expectation,
  // then predict for a request taken on the same edge.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: slot 0x%0h last %0b", slot_o, last_o);
        err_cnt++;
      end else begin
        got_due = due_results.pop_front();
        check_field("hit",              32'(got_due.hit),    32'(hit_o));
        check_field("slot",             32'(got_due.slot),   32'(slot_o));
        check_field("writeback_needed", 32'(got_due.wb),     32'(writeback_needed_o));
        check_field("writeback_addr",   got_due.wb_addr,     writeback_addr_o);
        check_field("fill_needed",      32'(got_due.fill),   32'(fill_needed_o));
        check_field("flush_total",      32'(got_due.ftotal), 32'(flush_total_o));
        check_field("hit_total",        got_due.hit_total,   hit_total_o);
        check_field("miss_total",       got_due.miss_total,  miss_total_o);
        check_field("last",             32'(got_due.last),   32'(last_o));
      end
    end
    if (in_valid_i && !in_stall_o) begin
      predict_directory(func_i, sector_addr_i);
      reqs_taken++;
    end
    req_fire <= in_valid_i && !in_stall_o;
  end

  // Watchdog: end the run when nothing transfers for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = $urandom();
    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hFFFF_FFFF;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Sender sparse idling, receiver stalls heavily.
    send_idle_pct = 11;
    recv_idle_pct = 70;
    queue_request(FUNC_READ,  32'h0000_0000);  // miss into an empty directory
    queue_request(FUNC_READ,  32'h0000_0000);  // read hit
    queue_request(FUNC_WRITE, 32'hFFFF_FFFF);  // write miss, clock steps twice
    queue_request(FUNC_WRITE, 32'hFFFF_FFFF);  // write hit
    queue_request(FUNC_MARK,  32'h0000_0000);  // mark dirty on a hit
    queue_request(FUNC_MARK,  32'h1234_5678);  // mark dirty on a miss
    queue_request(FUNC_READ,  32'hFFFF_FFFF);
    queue_request(FUNC_SYNC,  32'hDEAD_BEEF);  // two dirty entries flushed
    queue_request(FUNC_SYNC,  32'h0000_0000);  // nothing dirty, no result
    queue_request(FIRST_UNUSED_FUNC,        32'h5555_5555);
    queue_request(FIRST_UNUSED_FUNC + 3'd1, 32'hAAAA_AAAA);
    queue_request(FIRST_UNUSED_FUNC + 3'd2, 32'hFFFF_FFFF);
    queue_request(FUNC_WRITE, 32'hA5A5_A5A5);
    queue_request(FUNC_READ,  32'h5A5A_5A5A);
    queue_request(FUNC_INVAL, 32'hFFFF_FFFF);  // flush one, then empty
    queue_request(FUNC_INVAL, 32'h0000_0000);  // empty directory, no result
    queue_request(FUNC_READ,  32'hA5A5_A5A5);  // miss after invalidate
    queue_request(FUNC_MARK,  32'hA5A5_A5A5);
    queue_request(FUNC_SYNC,  32'h0000_0000);
    for (int k = 0; k < ITEMS_PER_PASS; k++) queue_random_request();
    drain();

    // Sender idles heavily, receiver stalls now and then.
    send_idle_pct = 70;
    recv_idle_pct = 11;
    for (int k = 0; k < ITEMS_PER_PASS; k++) queue_random_request();
    drain();

    // Back to back on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int k = 0; k < ITEMS_PER_PASS; k++) queue_random_request();
    drain();

    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/lwscd_pkg.sv
hw/rtl/lwscd_mem.sv
hw/rtl/lwscd_outreg.sv
hw/rtl/lru_writeback_sector_cache_directory.sv
sim/tb.sv
